FILE: rtl/spd_pkg.sv
// Package for the shortest-path engine: sizes, request and result
// structs, opcode and status codes, and controller/datapath interface types.
// No dependencies.
package spd_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES    = 64;
	localparam int WEIGHT_BITS  = 16;
	localparam int VTX_BITS     = $clog2(MAX_VERTICES);
	localparam int VCNT_BITS    = VTX_BITS + 1;
	localparam int EDGE_BITS    = $clog2(MAX_EDGES);
	localparam int ECNT_BITS    = EDGE_BITS + 1;
	localparam int DIST_BITS    = 20;
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_APPEND = 2'd0;
	localparam opcode_t OP_QUERY  = 2'd1;
	localparam opcode_t OP_CLEAR  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_PATH    = 2'd0;
	localparam status_t ST_NO_SRC  = 2'd1;
	localparam status_t ST_NO_DST  = 2'd2;
	localparam status_t ST_UNREACH = 2'd3;

	typedef struct packed {
		opcode_t     opcode;
		logic [3:0]  from_vertex;
		logic [3:0]  to_vertex;
		logic [15:0] edge_weight_in;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  path_vertex;
		logic [19:0] path_distance;
		logic        last;
	} out_t;

	typedef struct packed {
		logic append;
		logic clear;
		logic init;
		logic req_err;
		logic round_start;
		logic vertex_start;
		logic issue;
		logic next_vertex;
		logic commit;
		logic set_unreach;
		logic walk_start;
		logic walk_step;
		logic emit_path;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic dst_miss;
		logic src_miss;
		logic dst_done;
		logic order_end;
		logic edge_end;
		logic found;
		logic solved_full;
		logic walk_end;
		logic path_last;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/shortest_path_dijkstra.sv
// Append, clear and unused requests are handled without leaving idle; an error result goes out via the error state.
// A query runs rounds of vertex and edge scans, then walks the predecessors back from the destination
// and emits one result per path vertex; the edge scan loop sets its length.
// One request is worked on at a time; the next is taken once the query finishes.
// Reset clears the edge list and sets vertex_count to 16; stores hold junk until written.
// Top level of the shortest-path engine; depends on spd_pkg, spd_ctrl, spd_datapath.
module shortest_path_dijkstra (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  spd_pkg::in_t         in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spd_pkg::out_t        out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// The configuration register is the raw five-bit vertex count; values above
	// the vertex limit behave as the limit.
	logic [4:0]                         vcount_q;
	logic [spd_pkg::VCNT_BITS-1:0]      live_count;
	logic                               cfg_wr;
	spd_pkg::cmd_t                      cmd;
	spd_pkg::stat_t                     stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {27'd0, vcount_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
		end else if (cfg_wr) begin
			vcount_q <= pwdata[4:0];
		end
	end

	assign live_count = (vcount_q > 5'(spd_pkg::MAX_VERTICES))
		? spd_pkg::VCNT_BITS'(spd_pkg::MAX_VERTICES)
		: spd_pkg::VCNT_BITS'(vcount_q);

	// The controller sequences rounds, vertex scans and the path walk.
	spd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_data.opcode),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// The datapath holds the edge store, the vertex arrays and the result register.
	spd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.live_count (live_count),
		.cmd        (cmd),
		.out_ready  (out_ready),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule

FILE: rtl/spd_ctrl.sv
// Controller state machine of the shortest-path engine.
// Depends on spd_pkg for the command and status structs and opcodes.
module spd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  spd_pkg::opcode_t opcode,
	input  spd_pkg::stat_t  stat,
	output logic            in_ready,
	output spd_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ROUND  = 3'd1;
	localparam logic [2:0] S_VSTART = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_RDONE  = 3'd4;
	localparam logic [2:0] S_WALK   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;
	localparam logic [2:0] S_ERR    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						spd_pkg::OP_APPEND: cmd.append = 1'b1;
						spd_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
						spd_pkg::OP_QUERY: begin
							if (stat.dst_miss || stat.src_miss) begin
								cmd.req_err = 1'b1;
								state_nxt   = S_ERR;
							end else begin
								cmd.init  = 1'b1;
								state_nxt = S_ROUND;
							end
						end
						default: ;
					endcase
				end
			end
			S_ROUND: begin
				if (stat.dst_done) begin
					cmd.walk_start = 1'b1;
					state_nxt      = S_WALK;
				end else begin
					cmd.round_start = 1'b1;
					state_nxt       = S_VSTART;
				end
			end
			S_VSTART: begin
				if (stat.order_end) begin
					state_nxt = S_RDONE;
				end else begin
					cmd.vertex_start = 1'b1;
					state_nxt        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.edge_end) begin
					cmd.next_vertex = 1'b1;
					state_nxt       = S_VSTART;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			S_RDONE: begin
				if (!stat.found || stat.solved_full) begin
					cmd.set_unreach = 1'b1;
					state_nxt       = S_ERR;
				end else begin
					cmd.commit = 1'b1;
					state_nxt  = S_ROUND;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_end) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_path = 1'b1;
					if (stat.path_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTHESIS
	// A round is only closed out by a commit when a candidate was found.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.found)
		else $error("commit without a candidate");

	// Once the walk ends, the next cycle is spent emitting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && stat.walk_end |=> (state_q == S_EMIT))
		else $error("walk did not hand over to emit");

	// No new request is taken while a query is scanning edges.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !in_ready)
		else $error("request accepted during a scan");
`endif

endmodule

FILE: rtl/spd_datapath.sv
// Datapath of the shortest-path engine: edge store, per-query vertex
// arrays, edge scan compare, path walk and the result register.
// Depends on spd_pkg.
module spd_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spd_pkg::in_t                   in_data,
	input  logic [spd_pkg::VCNT_BITS-1:0]  live_count,
	input  spd_pkg::cmd_t                  cmd,
	input  logic                           out_ready,
	output spd_pkg::stat_t                 stat,
	output logic                           out_valid,
	output spd_pkg::out_t                  out_data
);

	localparam int VB = spd_pkg::VTX_BITS;
	localparam int CB = spd_pkg::VCNT_BITS;
	localparam int EB = spd_pkg::EDGE_BITS;
	localparam int NB = spd_pkg::ECNT_BITS;
	localparam int DB = spd_pkg::DIST_BITS;
	localparam int WB = spd_pkg::WEIGHT_BITS;
	localparam int NV = spd_pkg::MAX_VERTICES;
	localparam int NE = spd_pkg::MAX_EDGES;

	// Edge store.
	logic [VB-1:0] tail_mem [NE];
	logic [VB-1:0] head_mem [NE];
	logic [WB-1:0] cost_mem [NE];
	logic [NB-1:0] edge_total_q;
	logic [VB-1:0] rd_tail_s1;
	logic [VB-1:0] rd_head_s1;
	logic [WB-1:0] rd_cost_s1;
	logic          rd_vld_s1;

	// Per-query state.
	logic [DB-1:0] dist_q  [NV];
	logic [VB-1:0] pred_q  [NV];
	logic [VB-1:0] order_q [NV];
	logic [NV-1:0] done_q;
	logic [CB-1:0] solved_q;
	logic [VB-1:0] src_q;
	logic [VB-1:0] dst_q;
	spd_pkg::status_t err_q;

	// Scan state.
	logic [CB-1:0] oidx_q;
	logic [NB-1:0] eidx_q;
	logic [VB-1:0] u_q;
	logic [DB-1:0] bdu_q;
	logic          found_q;
	logic [DB-1:0] min_d_q;
	logic [VB-1:0] min_v_q;
	logic [VB-1:0] min_p_q;

	// Path walk.
	logic [VB-1:0]    path_v_q [NV];
	logic [DB-1:0]    path_d_q [NV];
	logic [CB-1:0]    plen_q;
	logic [VB-1:0]    walk_v_q;

	logic             out_valid_q;
	spd_pkg::out_t    out_q;

	logic             append_ok;
	logic [VB-1:0]    u_sel;
	logic [VB-1:0]    dist_ra;
	logic [DB-1:0]    dist_rd;
	logic [DB:0]      sum;
	logic [DB-1:0]    cand_d;
	logic             cand_ok;
	logic [VB-1:0]    emit_idx;

	assign append_ok = ({1'b0, in_data.from_vertex} < live_count)
		&& ({1'b0, in_data.to_vertex} < live_count)
		&& (in_data.from_vertex != in_data.to_vertex)
		&& (edge_total_q < NB'(NE));

	// One shared read port on the distance array.
	assign u_sel   = order_q[oidx_q[VB-1:0]];
	assign dist_ra = cmd.walk_step ? walk_v_q : u_sel;
	assign dist_rd = dist_q[dist_ra];

	assign sum     = {1'b0, bdu_q} + (DB+1)'(rd_cost_s1);
	assign cand_d  = sum[DB] ? spd_pkg::DIST_MAX : sum[DB-1:0];
	assign cand_ok = rd_vld_s1 && (rd_tail_s1 == u_q)
		&& ({1'b0, rd_head_s1} < live_count) && !done_q[rd_head_s1];

	assign emit_idx = VB'(plen_q - CB'(1));

	always_comb begin
		stat.dst_miss    = {1'b0, in_data.to_vertex} >= live_count;
		stat.src_miss    = {1'b0, in_data.from_vertex} >= live_count;
		stat.dst_done    = done_q[dst_q];
		stat.order_end   = (oidx_q == solved_q);
		stat.edge_end    = (eidx_q == edge_total_q);
		stat.found       = found_q;
		stat.solved_full = (solved_q == CB'(NV));
		stat.walk_end    = (walk_v_q == src_q) || (plen_q == CB'(NV - 1));
		stat.path_last   = (plen_q == CB'(1));
		stat.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.append && append_ok) begin
			tail_mem[edge_total_q[EB-1:0]] <= in_data.from_vertex;
			head_mem[edge_total_q[EB-1:0]] <= in_data.to_vertex;
			cost_mem[edge_total_q[EB-1:0]] <= in_data.edge_weight_in[WB-1:0];
		end
		rd_tail_s1 <= tail_mem[eidx_q[EB-1:0]];
		rd_head_s1 <= head_mem[eidx_q[EB-1:0]];
		rd_cost_s1 <= cost_mem[eidx_q[EB-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			solved_q     <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.clear) begin
				edge_total_q <= '0;
			end else if (cmd.append && append_ok) begin
				edge_total_q <= edge_total_q + NB'(1);
			end
			if (cmd.init) begin
				solved_q <= CB'(1);
			end else if (cmd.commit) begin
				solved_q <= solved_q + CB'(1);
			end
			if (cmd.emit_path || cmd.emit_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_err) begin
			err_q <= stat.dst_miss ? spd_pkg::ST_NO_DST : spd_pkg::ST_NO_SRC;
		end else if (cmd.set_unreach) begin
			err_q <= spd_pkg::ST_UNREACH;
		end
		if (cmd.init) begin
			src_q                      <= in_data.from_vertex;
			dst_q                      <= in_data.to_vertex;
			done_q                     <= NV'(1) << in_data.from_vertex;
			dist_q[in_data.from_vertex] <= '0;
			order_q[0]                 <= in_data.from_vertex;
		end else if (cmd.commit) begin
			order_q[solved_q[VB-1:0]] <= min_v_q;
			dist_q[min_v_q]           <= min_d_q;
			pred_q[min_v_q]           <= min_p_q;
			done_q[min_v_q]           <= 1'b1;
		end
		if (cmd.round_start) begin
			oidx_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.next_vertex) begin
			oidx_q <= oidx_q + CB'(1);
		end
		if (cmd.vertex_start) begin
			u_q    <= u_sel;
			bdu_q  <= dist_rd;
			eidx_q <= '0;
		end else if (cmd.issue) begin
			eidx_q <= eidx_q + NB'(1);
		end
		// Strictly smaller wins, so the first candidate keeps a tie.
		if (cand_ok && (!found_q || cand_d < min_d_q)) begin
			found_q <= 1'b1;
			min_d_q <= cand_d;
			min_v_q <= rd_head_s1;
			min_p_q <= u_q;
		end
		if (cmd.walk_start) begin
			walk_v_q <= dst_q;
			plen_q   <= '0;
		end else if (cmd.walk_step) begin
			path_v_q[plen_q[VB-1:0]] <= walk_v_q;
			path_d_q[plen_q[VB-1:0]] <= dist_rd;
			walk_v_q                 <= pred_q[walk_v_q];
			plen_q                   <= plen_q + CB'(1);
		end else if (cmd.emit_path) begin
			plen_q <= plen_q - CB'(1);
		end
		if (cmd.emit_path) begin
			out_q.status        <= spd_pkg::ST_PATH;
			out_q.path_vertex   <= path_v_q[emit_idx];
			out_q.path_distance <= path_d_q[emit_idx];
			out_q.last          <= stat.path_last;
		end else if (cmd.emit_err) begin
			out_q.status        <= err_q;
			out_q.path_vertex   <= '0;
			out_q.path_distance <= '0;
			out_q.last          <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= NB'(NE))
		else $error("edge count beyond the store");

	assert property (@(posedge clk) disable iff (!arst_n)
		solved_q <= CB'(NV))
		else $error("solved count beyond the vertex range");

	// The source stays solved for the whole query.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vertex_start |-> done_q[src_q])
		else $error("source not marked solved");

	// A new result is only loaded when the register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_path || cmd.emit_err) |-> (!out_valid_q || out_ready))
		else $error("result overwritten");
`endif

endmodule
